// ===== src/aod_pkg.sv =====
package aod_pkg;

    // sample and register widths
    localparam int SAMPLE_BITS = 15;
    localparam int CFG_W       = 15;
    localparam int CNT_W       = 8;
    localparam int IDX_W       = 3;

    // filter accumulator holds 3*filt + sample
    localparam int ACC_W = SAMPLE_BITS + 3;
    // square of one axis and sum of three squares
    localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W = SQ_W + 2;
    localparam int GSQ_W = 2 * CFG_W;
    localparam int CMP_W = (SUM_W > GSQ_W) ? SUM_W : GSQ_W;
    // planar compares against 15-bit thresholds
    localparam int PL_W  = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 8 * ((3 * SAMPLE_BITS + 7) / 8);
    localparam int OUT_DATA_W = 8;

    // classification queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register reset values
    localparam logic [CFG_W-1:0] GRAVITY_MIN_RST  = CFG_W'(700);
    localparam logic [CFG_W-1:0] GRAVITY_MAX_RST  = CFG_W'(1300);
    localparam logic [CFG_W-1:0] PLANAR_MIN_RST   = CFG_W'(500);
    localparam logic [CFG_W-1:0] AXIS_MARGIN_RST  = CFG_W'(150);
    localparam logic [CNT_W-1:0] STABLE_COUNT_RST = CNT_W'(3);

    typedef enum logic [IDX_W-1:0] {
        REG_GRAVITY_MIN  = 3'd0,
        REG_GRAVITY_MAX  = 3'd1,
        REG_PLANAR_MIN   = 3'd2,
        REG_AXIS_MARGIN  = 3'd3,
        REG_STABLE_COUNT = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ORI_0   = 2'd0,
        ORI_90  = 2'd1,
        ORI_180 = 2'd2,
        ORI_270 = 2'd3
    } t_orient;

    // thresholds used by the classifier
    typedef struct packed {
        logic [CFG_W-1:0] gravity_min;
        logic [CFG_W-1:0] gravity_max;
        logic [CFG_W-1:0] planar_min;
        logic [CFG_W-1:0] axis_margin;
    } t_cfg;

    // one classified item: keep low means discard the candidate
    typedef struct packed {
        logic    keep;
        t_orient orient;
    } t_cls;

endpackage

// ===== src/aod_front.sv =====
module aod_front
    import aod_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_y,
    input  logic signed [SAMPLE_BITS-1:0] i_z,
    input  t_cfg                          i_cfg,
    output logic                          o_ready,
    input  logic                          i_q_full,
    output logic                          o_push,
    output t_cls                          o_cls
);

    // low-pass step, (3*f + s) / 4 truncated toward zero
    function automatic logic signed [SAMPLE_BITS-1:0] smooth(
        input logic signed [SAMPLE_BITS-1:0] f,
        input logic signed [SAMPLE_BITS-1:0] s
    );
        logic signed [ACC_W-1:0] acc;
        logic        [ACC_W-1:0] adj;
        acc = (ACC_W'(f) <<< 1) + ACC_W'(f) + ACC_W'(s);
        adj = acc + (acc[ACC_W-1] ? ACC_W'(3) : ACC_W'(0));
        return adj[SAMPLE_BITS+1:2];
    endfunction

    logic                          w_en;
    logic                          w_accept;

    logic signed [SAMPLE_BITS-1:0] r_filt_x, r_filt_y, r_filt_z;
    logic                          r_primed;
    logic                          r_a_valid;

    logic signed [2*SAMPLE_BITS-1:0] w_prod_x, w_prod_y, w_prod_z;
    logic        [SQ_W-1:0]          r_sq_x, r_sq_y, r_sq_z;
    logic        [SAMPLE_BITS-1:0]   r_ax, r_ay;
    logic                            r_nx, r_ny;
    logic                            r_b_valid;
    logic        [GSQ_W-1:0]         r_gmin_sq, r_gmax_sq;

    logic [CMP_W-1:0]       w_g2;
    logic                   w_out_win;
    logic                   w_x_dom;
    logic [SAMPLE_BITS-1:0] w_big, w_diff;
    logic                   w_flat;

    // whole front advances unless the last stage is blocked by a full queue
    assign w_en     = !(r_b_valid && i_q_full);
    assign o_ready  = w_en;
    assign w_accept = i_valid && w_en;

    // filter state, updated once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_x  <= '0;
            r_filt_y  <= '0;
            r_filt_z  <= '0;
            r_primed  <= 1'b0;
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= w_accept;
            if (w_accept) begin
                r_primed <= 1'b1;
                if (!r_primed) begin
                    r_filt_x <= i_x;
                    r_filt_y <= i_y;
                    r_filt_z <= i_z;
                end else begin
                    r_filt_x <= smooth(r_filt_x, i_x);
                    r_filt_y <= smooth(r_filt_y, i_y);
                    r_filt_z <= smooth(r_filt_z, i_z);
                end
            end
        end
    end

    // squares and planar magnitudes of the filtered vector
    assign w_prod_x = (2*SAMPLE_BITS)'(r_filt_x) * (2*SAMPLE_BITS)'(r_filt_x);
    assign w_prod_y = (2*SAMPLE_BITS)'(r_filt_y) * (2*SAMPLE_BITS)'(r_filt_y);
    assign w_prod_z = (2*SAMPLE_BITS)'(r_filt_z) * (2*SAMPLE_BITS)'(r_filt_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_x <= w_prod_x[SQ_W-1:0];
            r_sq_y <= w_prod_y[SQ_W-1:0];
            r_sq_z <= w_prod_z[SQ_W-1:0];
            r_ax   <= r_filt_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_filt_x) : r_filt_x;
            r_ay   <= r_filt_y[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_filt_y) : r_filt_y;
            r_nx   <= r_filt_x[SAMPLE_BITS-1];
            r_ny   <= r_filt_y[SAMPLE_BITS-1];
        end
    end

    // gravity window squared, registered from the configuration registers
    always_ff @(posedge i_clk) begin
        r_gmin_sq <= GSQ_W'(i_cfg.gravity_min) * GSQ_W'(i_cfg.gravity_min);
        r_gmax_sq <= GSQ_W'(i_cfg.gravity_max) * GSQ_W'(i_cfg.gravity_max);
    end

    // window check, flat and diagonal checks, orientation pick
    always_comb begin
        w_g2      = CMP_W'(r_sq_x) + CMP_W'(r_sq_y) + CMP_W'(r_sq_z);
        w_out_win = (w_g2 < CMP_W'(r_gmin_sq)) || (w_g2 > CMP_W'(r_gmax_sq));
        w_x_dom   = r_ax > r_ay;
        w_big     = w_x_dom ? r_ax : r_ay;
        w_diff    = w_x_dom ? (r_ax - r_ay) : (r_ay - r_ax);
        w_flat    = (PL_W'(w_big) < PL_W'(i_cfg.planar_min)) ||
                    (PL_W'(w_diff) < PL_W'(i_cfg.axis_margin));
        o_cls.keep = !w_out_win && !w_flat;
        if (w_x_dom) begin
            o_cls.orient = r_nx ? ORI_180 : ORI_0;
        end else begin
            o_cls.orient = r_ny ? ORI_270 : ORI_90;
        end
    end

    assign o_push = r_b_valid && !i_q_full;

endmodule

// ===== src/aod_queue.sv =====
module aod_queue
    import aod_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cls o_data
);

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/aod_back.sv =====
module aod_back
    import aod_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_cls             i_data,
    output logic             o_pop,
    input  logic [CNT_W-1:0] i_stable_count,
    output logic             o_valid,
    input  logic             i_ready,
    output t_orient          o_orient
);

    logic             r_cand_valid, n_cand_valid;
    t_orient          r_cand_orient, n_cand_orient;
    logic [CNT_W-1:0] r_cand_hits, n_cand_hits;
    t_orient          r_current, n_current;
    logic             r_out_valid, n_out_valid;
    t_orient          r_out_orient, n_out_orient;

    // take an item when the output register is free or being drained
    assign o_pop = !i_empty && (!r_out_valid || i_ready);

    // debounce of the candidate orientation
    always_comb begin
        n_cand_valid  = r_cand_valid;
        n_cand_orient = r_cand_orient;
        n_cand_hits   = r_cand_hits;
        n_current     = r_current;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_orient  = r_out_orient;
        if (o_pop) begin
            if (!i_data.keep) begin
                n_cand_valid = 1'b0;
                n_cand_hits  = '0;
            end else if (!r_cand_valid || (i_data.orient != r_cand_orient)) begin
                n_cand_valid  = 1'b1;
                n_cand_orient = i_data.orient;
                n_cand_hits   = CNT_W'(1);
            end else begin
                if (r_cand_hits < i_stable_count) begin
                    n_cand_hits = r_cand_hits + 1'b1;
                end
                if ((n_cand_hits >= i_stable_count) && (r_cand_orient != r_current)) begin
                    n_current    = r_cand_orient;
                    n_out_valid  = 1'b1;
                    n_out_orient = r_cand_orient;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_valid  <= 1'b0;
            r_cand_orient <= ORI_0;
            r_cand_hits   <= '0;
            r_current     <= ORI_0;
            r_out_valid   <= 1'b0;
        end else begin
            r_cand_valid  <= n_cand_valid;
            r_cand_orient <= n_cand_orient;
            r_cand_hits   <= n_cand_hits;
            r_current     <= n_current;
            r_out_valid   <= n_out_valid;
        end
    end

    // result register, payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out_orient <= n_out_orient;
    end

    assign o_valid  = r_out_valid;
    assign o_orient = r_out_orient;

endmodule

// ===== src/accel_orientation_detector_core.sv =====
// channel    | direction | payload
// s_axis     | in        | tdata: accel_x[14:0] accel_y[29:15] accel_z[44:30], zero pad to 48
// m_axis     | out       | tdata: orientation[1:0], zero pad to 8
// cfg        | in        | idx 0..4: gravity_min gravity_max planar_min axis_margin stable_count
//
// one sample per cycle sustained while tready is high; the filter feedback is combinational
// a sample passes the filter, square and queue registers before the result register
// a four-item classification queue parts the filter front from the debounce back
// s_axis tready drops only when that queue is full and its next item is waiting
// synchronous active-low reset; no clearing pass, ready the cycle after reset
module accel_orientation_detector_core
    import aod_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // accel_x, accel_y, accel_z from bit 0 up
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // orientation from bit 0 up
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    t_cfg             r_cfg;
    logic [CNT_W-1:0] r_stable_count;

    logic    w_push, w_pop, w_full, w_empty;
    t_cls    w_push_data, w_pop_data;
    t_orient w_orient;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity_min <= GRAVITY_MIN_RST;
            r_cfg.gravity_max <= GRAVITY_MAX_RST;
            r_cfg.planar_min  <= PLANAR_MIN_RST;
            r_cfg.axis_margin <= AXIS_MARGIN_RST;
            r_stable_count    <= STABLE_COUNT_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_GRAVITY_MIN:  r_cfg.gravity_min <= i_cfg_wdata;
                REG_GRAVITY_MAX:  r_cfg.gravity_max <= i_cfg_wdata;
                REG_PLANAR_MIN:   r_cfg.planar_min  <= i_cfg_wdata;
                REG_AXIS_MARGIN:  r_cfg.axis_margin <= i_cfg_wdata;
                REG_STABLE_COUNT: r_stable_count    <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // filter and classifier
    aod_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_x      (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_y      (i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_z      (i_s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .i_cfg    (r_cfg),
        .o_ready  (o_s_axis_tready),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cls    (w_push_data)
    );

    // classification queue
    aod_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_data)
    );

    // debounce and result register
    aod_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_data         (w_pop_data),
        .o_pop          (w_pop),
        .i_stable_count (r_stable_count),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_orient       (w_orient)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - 2)'(0), w_orient};

endmodule

// ===== src/aod_checker.sv =====
module aod_checker
    import aod_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic [1:0] r_last;

    // last reported orientation, 0 degrees after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= ORI_0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_last <= o_m_axis_tdata[1:0];
        end
    end

    // a result always reports a change of orientation
    a_new_orient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready) |-> (o_m_axis_tdata[1:0] != r_last))
        else $error("result repeats the reported orientation");

    // reset leaves no result and the input ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("block not idle after reset");

    // padding bits of the result stay zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[OUT_DATA_W-1:2] == '0))
        else $error("result padding not zero");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind accel_orientation_detector_core aod_checker u_aod_checker (.*);
